// File: rtl/core/klt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types and constants of the keyed list table: operation and status
// codes, request and result beats, controller states.
// ----------------------------------------------------------------------------
package klt_pkg;

  localparam int unsigned KLT_DEPTH      = 64;
  localparam int unsigned KLT_DATA_WIDTH = 32;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned ItemDataW      = 32;
  localparam int unsigned PosW           = 6;
  localparam int unsigned CntOutW        = 7;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_GET    = 2'd2,
    FUNC_AT     = 2'd3
  } klt_func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_OUT_RANGE = 2'd3
  } klt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_AT
  } klt_state_e;

  typedef struct packed {
    klt_func_e              func;
    logic signed [KeyW-1:0] item_key;
    logic [ItemDataW-1:0]   item_data;
    logic [PosW-1:0]        position;
  } klt_req_t;

  typedef struct packed {
    klt_status_e            status;
    logic signed [KeyW-1:0] found_key;
    logic [ItemDataW-1:0]   found_data;
    logic [CntOutW-1:0]     entry_count;
  } klt_res_t;

endpackage

// File: rtl/core/klt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_mem
// Entry store: simple dual-port synchronous RAM, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module klt_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 64,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/klt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klt_ctrl
// Sequencer of the keyed list table: entry count, linear key search with one
// read per cycle, shift-down of later entries on remove, result register.
// ----------------------------------------------------------------------------
module klt_ctrl import klt_pkg::*; #(
  parameter int unsigned Depth     = KLT_DEPTH,
  parameter int unsigned DataWidth = KLT_DATA_WIDTH,
  localparam int unsigned AW       = $clog2(Depth),
  localparam int unsigned CW       = $clog2(Depth + 1),
  localparam int unsigned EW       = KeyW + DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  klt_req_t      req_i,
  output logic          res_valid_o,
  output klt_res_t      res_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [EW-1:0] mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [EW-1:0] mem_rdata_i
);

  klt_state_e             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          idx_q, idx_d;
  klt_func_e              op_q, op_d;
  logic signed [KeyW-1:0] key_q, key_d;
  klt_res_t               res_q, res_d;
  logic                   vld_q, vld_d;

  logic                   accept;
  logic signed [KeyW-1:0] rd_key;
  logic [ItemDataW-1:0]   rd_data;
  logic [CW-1:0]          idx_ext;
  logic                   hit;
  logic                   last;
  logic                   shift_last;
  logic                   full;
  logic                   pos_ok;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign rd_key      = mem_rdata_i[EW-1 -: KeyW];
  assign rd_data     = ItemDataW'(mem_rdata_i[DataWidth-1:0]);
  assign idx_ext     = CW'(idx_q);
  assign hit         = (rd_key == key_q);
  // entry idx_q, now on the read data, is the last stored entry
  assign last        = ((idx_ext + CW'(1)) == cnt_q);
  assign shift_last  = ((idx_ext + CW'(2)) == cnt_q);
  assign full        = (cnt_q == CW'(Depth));
  assign pos_ok      = (32'(req_i.position) < 32'(cnt_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.func)
            FUNC_APPEND: state_d = S_IDLE;
            FUNC_REMOVE,
            FUNC_GET:    state_d = (cnt_q == '0) ? S_IDLE : S_SEARCH;
            FUNC_AT:     state_d = pos_ok ? S_AT : S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = (op_q == FUNC_REMOVE && !last) ? S_SHIFT : S_IDLE;
        end else if (last) begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (shift_last) begin
          state_d = S_IDLE;
        end
      end
      S_AT:    state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    op_d        = op_q;
    key_d       = key_q;
    res_d       = res_q;
    vld_d       = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q + AW'(1);
    unique case (state_q)
      S_IDLE: begin
        mem_raddr_o = '0;
        if (accept) begin
          op_d  = req_i.func;
          key_d = req_i.item_key;
          idx_d = '0;
          res_d = '{status: ST_OK, found_key: '0, found_data: '0,
                    entry_count: CntOutW'(cnt_q)};
          unique case (req_i.func)
            FUNC_APPEND: begin
              vld_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                mem_we_o          = 1'b1;
                mem_waddr_o       = cnt_q[AW-1:0];
                mem_wdata_o       = {req_i.item_key, DataWidth'(req_i.item_data)};
                cnt_d             = cnt_q + CW'(1);
                res_d.entry_count = CntOutW'(cnt_q + CW'(1));
              end
            end
            FUNC_REMOVE,
            FUNC_GET: begin
              if (cnt_q == '0) begin
                vld_d        = 1'b1;
                res_d.status = ST_NOT_FOUND;
              end
            end
            FUNC_AT: begin
              mem_raddr_o = AW'(req_i.position);
              if (!pos_ok) begin
                vld_d        = 1'b1;
                res_d.status = ST_OUT_RANGE;
              end
            end
            default: vld_d = 1'b0;
          endcase
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_d.status     = ST_OK;
          res_d.found_key  = rd_key;
          res_d.found_data = rd_data;
          if (op_q == FUNC_GET) begin
            vld_d = 1'b1;
          end else if (last) begin
            vld_d             = 1'b1;
            cnt_d             = cnt_q - CW'(1);
            res_d.entry_count = CntOutW'(cnt_q - CW'(1));
          end
          // otherwise idx_q stays the hole; read of idx_q+1 is in flight
        end else if (last) begin
          vld_d        = 1'b1;
          res_d.status = ST_NOT_FOUND;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_SHIFT: begin
        // rdata holds entry idx_q+1, moves into idx_q
        mem_we_o    = 1'b1;
        mem_raddr_o = idx_q + AW'(2);
        idx_d       = idx_q + AW'(1);
        if (shift_last) begin
          vld_d             = 1'b1;
          cnt_d             = cnt_q - CW'(1);
          res_d.entry_count = CntOutW'(cnt_q - CW'(1));
        end
      end
      S_AT: begin
        vld_d            = 1'b1;
        res_d.status     = ST_OK;
        res_d.found_key  = rd_key;
        res_d.found_data = rd_data;
      end
      default: vld_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    op_q  <= op_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("entry count above capacity");

  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.func == FUNC_APPEND && !full |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("append did not grow the table");

  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && state_d == S_IDLE |=> vld_q)
    else $error("operation ended without a result beat");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> CW'(mem_waddr_o) <= cnt_q)
    else $error("write beyond the packed list");

endmodule

// File: rtl/core/keyed_list_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_list_table_core
// Packed list of keyed entries in insertion order with append, remove by key,
// get by key and read at position.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a clock edge with start high and busy low.
//   Every request gives exactly one result beat on res_o, marked by
//   res_valid_o for one cycle; the receiver has no way to hold it off.
//   An append, and any request that fails its range check, is answered from
//   the idle state; a read at position waits for its RAM read in S_AT; get and
//   remove scan from position 0 up to the first match or the last entry, and
//   a remove that hits before the last entry then shifts the later ones down.
//   Entries live in one dual-port RAM with one read and one write per cycle;
//   search and shift each move one entry per cycle.
//   busy is low whenever the sequencer is idle, including the cycle in which
//   a result is shown. Reset empties the table at once (count to zero); the
//   RAM contents are not cleared.
// ----------------------------------------------------------------------------
module keyed_list_table_core import klt_pkg::*; #(
  parameter int unsigned Depth     = KLT_DEPTH,
  parameter int unsigned DataWidth = KLT_DATA_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  klt_req_t req_i,
  output logic     res_valid_o,
  output klt_res_t res_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned EW = KeyW + DataWidth;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  klt_ctrl #(
    .Depth     (Depth),
    .DataWidth (DataWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  klt_mem #(
    .Depth (Depth),
    .Width (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: verif/keyed_list_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_list_table_core_tb
// Self-checking bench for the keyed list table. A directed sequence covers
// the empty table, key extremes, duplicate keys and positions out of
// range. Randomized phases with shifting append bias then fill and drain the
// table. Every result beat is compared field by field against a table model
// kept in a scoreboard class.
// ----------------------------------------------------------------------------
module keyed_list_table_core_tb;
  import klt_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = KLT_DEPTH + 16;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned NumPhases   = 6;

  class klt_table_scoreboard;
    logic signed [KeyW-1:0] key_mem  [KLT_DEPTH];
    logic [ItemDataW-1:0]   data_mem [KLT_DEPTH];
    int unsigned            fill;
    klt_res_t               pending_q [$];
    int unsigned            mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int find_key(logic signed [KeyW-1:0] key);
      for (int i = 0; i < int'(fill); i++) begin
        if (key_mem[i] == key) return i;
      end
      return -1;
    endfunction

    // Advance the table model by one request beat and queue its result.
    function void note_request(klt_req_t req);
      klt_res_t res;
      int       hit;
      res        = '0;
      res.status = ST_OK;
      case (req.func)
        FUNC_APPEND: begin
          if (fill >= KLT_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            key_mem[fill]  = req.item_key;
            data_mem[fill] = req.item_data & ItemDataW'((64'd1 << KLT_DATA_WIDTH) - 64'd1);
            fill++;
          end
        end
        FUNC_REMOVE, FUNC_GET: begin
          hit = find_key(req.item_key);
          if (hit < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.found_key  = key_mem[hit];
            res.found_data = data_mem[hit];
            if (req.func == FUNC_REMOVE) begin
              for (int j = hit; j + 1 < int'(fill); j++) begin
                key_mem[j]  = key_mem[j+1];
                data_mem[j] = data_mem[j+1];
              end
              fill--;
            end
          end
        end
        default: begin
          if (req.position >= fill) begin
            res.status = ST_OUT_RANGE;
          end else begin
            res.found_key  = key_mem[req.position];
            res.found_data = data_mem[req.position];
          end
        end
      endcase
      res.entry_count = CntOutW'(fill);
      pending_q.push_back(res);
    endfunction

    function void flag(string what, klt_res_t want, klt_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s: exp st=%0d key=%h data=%h cnt=%0d | got st=%0d key=%h data=%h cnt=%0d",
                 $time, what, want.status, want.found_key, want.found_data, want.entry_count,
                 got.status, got.found_key, got.found_data, got.entry_count);
      end
    endfunction

    function void check_result(klt_res_t got);
      klt_res_t want;
      if (pending_q.size() == 0) begin
        flag("result beat with none pending", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status || got.found_key !== want.found_key ||
            got.found_data !== want.found_data || got.entry_count !== want.entry_count) begin
          flag("result mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  klt_req_t req_i = '0;
  logic     res_valid_o;
  klt_res_t res_o;

  klt_table_scoreboard sb = new();
  int unsigned stall_cycles = 0;

  keyed_list_table_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Monitor: result beat first, then the request beat taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_result(res_o);
      if (start && !busy) sb.note_request(req_i);
      if (res_valid_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $time, StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic klt_req_t make_req(klt_func_e f, logic [31:0] key, logic [31:0] data,
                                        logic [5:0] pos);
    klt_req_t r;
    r.func      = f;
    r.item_key  = key;
    r.item_data = data;
    r.position  = pos;
    return r;
  endfunction

  function automatic klt_req_t rand_req(int unsigned append_pct);
    klt_req_t r;
    r.func      = FUNC_APPEND;
    r.item_key  = $urandom();
    r.item_data = $urandom();
    r.position  = PosW'($urandom_range(0, 63));
    if ($urandom_range(0, 99) < append_pct) begin
      // small key pool so duplicates show up
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       r.item_key = 32'h7fff_ffff;
          1:       r.item_key = 32'h8000_0000;
          2:       r.item_key = 32'h0;
          3:       r.item_key = 32'hffff_ffff;
          default: r.item_key = $urandom_range(1, 6);
        endcase
      end
    end else begin
      r.func = klt_func_e'(2'($urandom_range(1, 3)));
      if (sb.fill != 0) begin
        if (r.func != FUNC_AT && $urandom_range(0, 3) != 0)
          r.item_key = sb.key_mem[$urandom_range(0, sb.fill - 1)];
        if (r.func == FUNC_AT && $urandom_range(0, 9) < 7)
          r.position = PosW'($urandom_range(0, sb.fill - 1));
      end
    end
    return r;
  endfunction

  task automatic send_req(input klt_req_t req, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned pct;
    bit          no_gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    send_req(make_req(FUNC_AT,     32'h0,         32'hffff_ffff, 6'd0), 1'b0);
    send_req(make_req(FUNC_GET,    32'h0,         32'h0,         6'd63), 1'b0);
    send_req(make_req(FUNC_REMOVE, 32'h7fff_ffff, 32'h0,         6'd0), 1'b0);
    // extremes and a duplicate key
    send_req(make_req(FUNC_APPEND, 32'h7fff_ffff, 32'hffff_ffff, 6'd63), 1'b0);
    send_req(make_req(FUNC_APPEND, 32'h8000_0000, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_APPEND, 32'h0,         32'ha5a5_a5a5, 6'd0), 1'b0);
    send_req(make_req(FUNC_APPEND, 32'h8000_0000, 32'h5a5a_5a5a, 6'd0), 1'b0);
    send_req(make_req(FUNC_APPEND, 32'hffff_ffff, 32'h1,         6'd0), 1'b0);
    send_req(make_req(FUNC_GET,    32'h8000_0000, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_AT,     32'h0,         32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_AT,     32'h0,         32'h0,         6'd4), 1'b0);
    send_req(make_req(FUNC_AT,     32'h0,         32'h0,         6'd5), 1'b0);
    send_req(make_req(FUNC_AT,     32'hffff_ffff, 32'hffff_ffff, 6'd63), 1'b0);
    // remove takes the lowest duplicate, later entries shift down
    send_req(make_req(FUNC_REMOVE, 32'h8000_0000, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_GET,    32'h8000_0000, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_AT,     32'h0,         32'h0,         6'd1), 1'b0);
    send_req(make_req(FUNC_REMOVE, 32'd12345,     32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_REMOVE, 32'h7fff_ffff, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_REMOVE, 32'hffff_ffff, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_GET,    32'h7fff_ffff, 32'h0,         6'd0), 1'b0);
    send_req(make_req(FUNC_AT,     32'h0,         32'h0,         6'd1), 1'b0);
    wait_drained();

    // append bias per phase swings the table between empty and full
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       pct = 70;
        1:       pct = 30;
        2:       pct = 92;
        3:       pct = 25;
        4:       pct = 60;
        default: pct = 88;
      endcase
      no_gap = (phase == 1 || phase == 4);
      for (int n = 0; n < PhaseItems; n++) send_req(rand_req(pct), no_gap);
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/klt_pkg.sv
rtl/core/klt_mem.sv
rtl/core/klt_ctrl.sv
rtl/core/keyed_list_table_core.sv
verif/keyed_list_table_core_tb.sv
